@@ src/teq_pkg.sv @@
`timescale 1ns / 1ps

package teq_pkg;

  // request commands
  localparam logic [1:0] CMD_SCHED   = 2'd0;
  localparam logic [1:0] CMD_REM_ONE = 2'd1;
  localparam logic [1:0] CMD_REM_ALL = 2'd2;
  localparam logic [1:0] CMD_TRIG    = 2'd3;

  // result status codes
  localparam logic [2:0] STAT_SCHEDULED = 3'd0;
  localparam logic [2:0] STAT_FULL      = 3'd1;
  localparam logic [2:0] STAT_REMOVED   = 3'd2;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd3;
  localparam logic [2:0] STAT_FIRED     = 3'd4;
  localparam logic [2:0] STAT_NONE      = 3'd5;

  localparam int unsigned ID_BITS = 16;

  // what every cell of the chain does this cycle
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_SHIFT
  } chain_op_e;

  typedef struct packed {
    chain_op_e op;
    logic      keep;  // on shift: head entry re-enters at the tail cell
  } chain_ctrl_t;

endpackage

@@ src/teq_cell.sv @@
`timescale 1ns / 1ps

module teq_cell #(
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  teq_pkg::chain_ctrl_t       ctrl_i,
  input  logic                       tail_i,
  input  logic [TIME_BITS-1:0]       new_time_i,
  input  logic [teq_pkg::ID_BITS-1:0] new_id_i,
  input  logic                       prev_valid_i,
  input  logic                       prev_gt_i,
  input  logic [TIME_BITS-1:0]       prev_time_i,
  input  logic [teq_pkg::ID_BITS-1:0] prev_id_i,
  input  logic                       next_valid_i,
  input  logic [TIME_BITS-1:0]       next_time_i,
  input  logic [teq_pkg::ID_BITS-1:0] next_id_i,
  input  logic [TIME_BITS-1:0]       head_time_i,
  input  logic [teq_pkg::ID_BITS-1:0] head_id_i,
  output logic                       valid_o,
  output logic [TIME_BITS-1:0]       time_o,
  output logic [teq_pkg::ID_BITS-1:0] id_o,
  output logic                       gt_o
);
  import teq_pkg::*;

  logic                 valid_q, valid_d;
  logic [TIME_BITS-1:0] time_q, time_d;
  logic [ID_BITS-1:0]   id_q, id_d;

  // empty or later than the new time: the new entry goes at or below here
  assign gt_o = !valid_q || (time_q > new_time_i);

  always_comb begin
    valid_d = valid_q;
    time_d  = time_q;
    id_d    = id_q;
    unique case (ctrl_i.op)
      OP_INSERT: begin
        if (prev_gt_i) begin
          valid_d = prev_valid_i;
          time_d  = prev_time_i;
          id_d    = prev_id_i;
        end else if (gt_o) begin
          valid_d = 1'b1;
          time_d  = new_time_i;
          id_d    = new_id_i;
        end
      end
      OP_SHIFT: begin
        if (ctrl_i.keep && tail_i) begin
          valid_d = 1'b1;
          time_d  = head_time_i;
          id_d    = head_id_i;
        end else begin
          valid_d = next_valid_i;
          time_d  = next_time_i;
          id_d    = next_id_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    time_q <= time_d;
    id_q   <= id_d;
  end

  assign valid_o = valid_q;
  assign time_o  = time_q;
  assign id_o    = id_q;

endmodule

@@ src/timer_event_queue_unit.sv @@
`timescale 1ns / 1ps

// Time-ordered timer event queue built as a sorted chain of DEPTH cells.
// Request channel: drive cmd_i, event_time_i, callback_id_i with start;
// the beat is taken on a rising edge where start is high and busy low.
// Result channel: every result beat shows for one cycle with result_valid_o;
// last_o marks the final beat of a request. The receiver cannot stall, so
// results are never held back and the block never waits on the output side.
// Outside a remove scan, cell 0 holds the earliest entry; equal times keep insertion order.
// Per request (n = entries held):
//   schedule   : busy stays low, next request can follow at once.
//   remove     : answered at once when empty; else busy is high while
//                the chain rotates once through its n entries via cell 0, which drops matches
//                and re-enters the rest at the tail.
//   trigger    : a beat per fired entry, or a single beat when none expired;
//                busy is high in the fire state, one fire per cycle pops cell 0.
// Reset (rst_ni low, asynchronous) empties the queue; no clearing pass is
// needed. The current time output is not reset; non-trigger results show zero.
module timer_event_queue_unit #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           cmd_i,
  input  logic [TIME_BITS-1:0] event_time_i,
  input  logic [15:0]          callback_id_i,
  output logic                 result_valid_o,
  output logic [2:0]           status_o,
  output logic [15:0]          fired_id_o,
  output logic [TIME_BITS-1:0] fired_time_o,
  output logic [TIME_BITS-1:0] now_time_o,
  output logic [4:0]           removed_count_o,
  output logic                 last_o
);
  import teq_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIRE = 2'd2;

  // chain taps
  logic [DEPTH-1:0]     c_valid;
  logic [DEPTH-1:0]     c_gt;
  logic [TIME_BITS-1:0] c_time [DEPTH];
  logic [ID_BITS-1:0]   c_id   [DEPTH];

  chain_ctrl_t ctrl;

  // control state
  logic [1:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] scan_q, scan_d;
  logic [CW-1:0] rem_q, rem_d;
  logic          found_q, found_d;
  logic          rv_q, rv_d;

  // request and result payload
  logic [1:0]           cmd_q, cmd_d;
  logic [TIME_BITS-1:0] time_q, time_d;
  logic [ID_BITS-1:0]   id_q, id_d;
  logic [2:0]           status_q, status_d;
  logic [ID_BITS-1:0]   fid_q, fid_d;
  logic [TIME_BITS-1:0] ftime_q, ftime_d;
  logic [TIME_BITS-1:0] now_q, now_d;
  logic [4:0]           rc_q, rc_d;
  logic                 last_q, last_d;

  logic          head_drop;
  logic          head_fire;
  logic          next_fire;
  logic [CW-1:0] rem_next;

  // ---------------------------------------------------------------- chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                 p_valid, p_gt, n_valid, tail;
    logic [TIME_BITS-1:0] p_time, n_time;
    logic [ID_BITS-1:0]   p_id, n_id;

    if (i == 0) begin : g_first
      assign p_valid = 1'b0;
      assign p_gt    = 1'b0;
      assign p_time  = '0;
      assign p_id    = '0;
    end else begin : g_mid
      assign p_valid = c_valid[i-1];
      assign p_gt    = c_gt[i-1];
      assign p_time  = c_time[i-1];
      assign p_id    = c_id[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign n_valid = 1'b0;
      assign n_time  = '0;
      assign n_id    = '0;
    end else begin : g_body
      assign n_valid = c_valid[i+1];
      assign n_time  = c_time[i+1];
      assign n_id    = c_id[i+1];
    end

    // last occupied cell takes the recirculated head during a remove scan
    assign tail = (count_q == CW'(i + 1));

    teq_cell #(
      .TIME_BITS (TIME_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .tail_i       (tail),
      .new_time_i   (event_time_i),
      .new_id_i     (callback_id_i),
      .prev_valid_i (p_valid),
      .prev_gt_i    (p_gt),
      .prev_time_i  (p_time),
      .prev_id_i    (p_id),
      .next_valid_i (n_valid),
      .next_time_i  (n_time),
      .next_id_i    (n_id),
      .head_time_i  (c_time[0]),
      .head_id_i    (c_id[0]),
      .valid_o      (c_valid[i]),
      .time_o       (c_time[i]),
      .id_o         (c_id[i]),
      .gt_o         (c_gt[i])
    );
  end

  // ---------------------------------------------------------- head checks
  // remove-one drops only the first match, remove-all every id match
  assign head_drop = c_valid[0] && (c_id[0] == id_q) &&
                     ((cmd_q == CMD_REM_ALL) || (!found_q && (c_time[0] == time_q)));
  assign rem_next  = rem_q + CW'(head_drop);

  // cell 1 tells whether the current fire is the final one
  assign head_fire = c_valid[0] && (c_time[0] <= time_q);
  assign next_fire = c_valid[1] && (c_time[1] <= time_q);

  // ------------------------------------------------------------ sequencer
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    scan_d   = scan_q;
    rem_d    = rem_q;
    found_d  = found_q;
    rv_d     = 1'b0;
    cmd_d    = cmd_q;
    time_d   = time_q;
    id_d     = id_q;
    status_d = status_q;
    fid_d    = fid_q;
    ftime_d  = ftime_q;
    now_d    = now_q;
    rc_d     = rc_q;
    last_d   = last_q;
    ctrl     = '{op: OP_HOLD, keep: 1'b0};

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_d  = cmd_i;
          time_d = event_time_i;
          id_d   = callback_id_i;
          unique case (cmd_i) inside
            CMD_SCHED: begin
              rv_d    = 1'b1;
              fid_d   = callback_id_i;
              ftime_d = '0;
              now_d   = '0;
              rc_d    = '0;
              last_d  = 1'b1;
              if (count_q == CW'(DEPTH)) begin
                status_d = STAT_FULL;
              end else begin
                status_d = STAT_SCHEDULED;
                ctrl.op  = OP_INSERT;
                count_d  = count_q + CW'(1);
              end
            end
            CMD_REM_ONE, CMD_REM_ALL: begin
              if (count_q == '0) begin
                rv_d     = 1'b1;
                status_d = STAT_NOT_FOUND;
                fid_d    = callback_id_i;
                ftime_d  = '0;
                now_d    = '0;
                rc_d     = '0;
                last_d   = 1'b1;
              end else begin
                state_d = ST_SCAN;
                scan_d  = count_q;
                rem_d   = '0;
                found_d = 1'b0;
              end
            end
            default: begin
              state_d = ST_FIRE;
            end
          endcase
        end
      end

      ST_SCAN: begin
        ctrl.op   = OP_SHIFT;
        ctrl.keep = !head_drop;
        scan_d    = scan_q - CW'(1);
        rem_d     = rem_next;
        if (head_drop) begin
          count_d = count_q - CW'(1);
          found_d = 1'b1;
        end
        if (scan_q == CW'(1)) begin
          rv_d     = 1'b1;
          status_d = (rem_next != '0) ? STAT_REMOVED : STAT_NOT_FOUND;
          fid_d    = id_q;
          ftime_d  = '0;
          now_d    = '0;
          rc_d     = (cmd_q == CMD_REM_ALL) ? 5'(rem_next) : 5'd0;
          last_d   = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      ST_FIRE: begin
        rv_d  = 1'b1;
        now_d = time_q;
        rc_d  = '0;
        if (head_fire) begin
          ctrl.op   = OP_SHIFT;
          ctrl.keep = 1'b0;
          count_d   = count_q - CW'(1);
          status_d  = STAT_FIRED;
          fid_d     = c_id[0];
          ftime_d   = c_time[0];
          last_d    = !next_fire;
          if (!next_fire) begin
            state_d = ST_IDLE;
          end
        end else begin
          status_d = STAT_NONE;
          fid_d    = '0;
          ftime_d  = '0;
          last_d   = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      scan_q  <= '0;
      rem_q   <= '0;
      found_q <= 1'b0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      scan_q  <= scan_d;
      rem_q   <= rem_d;
      found_q <= found_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    time_q   <= time_d;
    id_q     <= id_d;
    status_q <= status_d;
    fid_q    <= fid_d;
    ftime_q  <= ftime_d;
    now_q    <= now_d;
    rc_q     <= rc_d;
    last_q   <= last_d;
  end

  assign busy            = (state_q != ST_IDLE);
  assign result_valid_o  = rv_q;
  assign status_o        = status_q;
  assign fired_id_o      = fid_q;
  assign fired_time_o    = ftime_q;
  assign now_time_o      = now_q;
  assign removed_count_o = rc_q;
  assign last_o          = last_q;

  // ----------------------------------------------------------- assertions
  a_count_matches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(c_valid) == count_q)
    else $error("fill count disagrees with occupied cells");

  a_packed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((c_valid >> 1) & ~c_valid) == '0)
    else $error("chain has a hole below an occupied cell");

  // mid-rotation the wrap point passes through the head, so skip the scan
  a_head_sorted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (c_valid[1] && (state_q != ST_SCAN)) |-> (c_time[0] <= c_time[1]))
    else $error("head is not the earliest entry");

  a_fire_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (status_o == STAT_FIRED)) |-> ($past(state_q) == ST_FIRE))
    else $error("fired beat outside a trigger");

  a_full_keeps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (cmd_i == CMD_SCHED) && (count_q == CW'(DEPTH)))
      |=> $stable(count_q))
    else $error("rejected schedule changed the queue");

endmodule
